>>> sv/iba_pkg.sv
// shared types and constants for the indexed block allocator
`default_nettype none

package iba_pkg;

   localparam int DISK_BLOCKS     = 1024;
   localparam int MAX_FILE_BLOCKS = 64;
   localparam int MAX_FILES       = 1023;

   localparam int BLK_W  = 10;
   localparam int LEN_W  = 7;
   localparam int ID_W   = 10;
   localparam int CFG_W  = 11;
   localparam int STAT_W = 2;

   localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(1024);

   localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
   localparam logic [STAT_W-1:0] ST_INDEX = 2'd1;
   localparam logic [STAT_W-1:0] ST_SHORT = 2'd2;
   localparam logic [STAT_W-1:0] ST_FULL  = 2'd3;

   typedef struct packed {
      logic [BLK_W-1:0] index_block;
      logic [LEN_W-1:0] length;
   } req_type;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [ID_W-1:0]   file_id;
      logic [BLK_W-1:0]  block_number;
      logic              last;
   } rsp_type;

   typedef struct packed {
      logic              valid;
      logic [STAT_W-1:0] status;
      logic [ID_W-1:0]   file_id;
      logic [BLK_W-1:0]  index_block;
      logic [LEN_W-1:0]  length;
   } job_type;

   typedef enum logic [2:0] {
      F_IDLE,
      F_CLASSIFY,
      F_SCAN,
      F_SEND
   } front_state_type;

   typedef enum logic [2:0] {
      B_CLEAR,
      B_IDLE,
      B_MARK,
      B_EMIT,
      B_REPORT
   } back_state_type;

endpackage

`default_nettype wire

>>> sv/iba_ram.sv
// generic single write port ram with registered read
`default_nettype none

module iba_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2
) (
   input  wire logic                                  clock,
   input  wire logic                                  wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                      wr_data,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output      logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> sv/iba_front.sv
// front end: request checks and first-fit scan of the owner map
`default_nettype none

module iba_front #(
   parameter int MAX_FILE_BLOCKS = iba_pkg::MAX_FILE_BLOCKS
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   accept,
   input  wire iba_pkg::req_type                       req,
   input  wire logic [iba_pkg::CFG_W-1:0]              blocks_in_use,
   input  wire logic [iba_pkg::ID_W-1:0]               files,
   output      logic [iba_pkg::BLK_W-1:0]              map_rd_addr,
   input  wire logic                                   map_rd_data,
   output      logic                                   q_wr_en,
   output      logic [((MAX_FILE_BLOCKS > 1) ? $clog2(MAX_FILE_BLOCKS) : 1)-1:0] q_wr_addr,
   output      logic [iba_pkg::BLK_W-1:0]              q_wr_data,
   output      iba_pkg::job_type                       job,
   output      logic                                   busy
);

   localparam int CNT_W = $clog2(MAX_FILE_BLOCKS + 1);
   localparam int QA_W  = (MAX_FILE_BLOCKS > 1) ? $clog2(MAX_FILE_BLOCKS) : 1;
   localparam logic [iba_pkg::LEN_W-1:0] MAX_LEN = iba_pkg::LEN_W'(MAX_FILE_BLOCKS);
   localparam logic [iba_pkg::CFG_W-1:0] NB = iba_pkg::CFG_W'(iba_pkg::DISK_BLOCKS);
   localparam logic [iba_pkg::ID_W-1:0]  MAXF = iba_pkg::ID_W'(iba_pkg::MAX_FILES);

   iba_pkg::front_state_type state_ff, state_in;

   logic [iba_pkg::BLK_W-1:0]  idx_ff, idx_in;
   logic [iba_pkg::LEN_W-1:0]  len_ff, len_in;
   logic [iba_pkg::CFG_W-1:0]  limit_ff, limit_in;
   logic [iba_pkg::CFG_W-1:0]  scan_ff, scan_in;
   logic                       pend_ff, pend_in;
   logic [iba_pkg::BLK_W-1:0]  pend_addr_ff, pend_addr_in;
   logic [CNT_W-1:0]           found_ff, found_in;
   logic [iba_pkg::STAT_W-1:0] status_ff, status_in;
   logic [iba_pkg::ID_W-1:0]   id_ff, id_in;

   logic [iba_pkg::LEN_W-1:0]  found_ext;
   logic                       issue;
   logic                       hit;

   assign found_ext = iba_pkg::LEN_W'(found_ff);
   assign issue     = (scan_ff < limit_ff) && (found_ext < len_ff);
   assign hit       = (state_ff == iba_pkg::F_SCAN) && pend_ff && !map_rd_data
                      && (pend_addr_ff != idx_ff) && (found_ext < len_ff);

   // next state
   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      len_in       = len_ff;
      limit_in     = limit_ff;
      scan_in      = scan_ff;
      pend_in      = pend_ff;
      pend_addr_in = pend_addr_ff;
      found_in     = found_ff;
      status_in    = status_ff;
      id_in        = id_ff;
      case (state_ff)
         iba_pkg::F_IDLE: begin
            pend_in = 1'b0;
            if (accept) begin
               idx_in   = req.index_block;
               len_in   = req.length;
               limit_in = (blocks_in_use > NB) ? NB : blocks_in_use;
               state_in = iba_pkg::F_CLASSIFY;
            end
         end
         iba_pkg::F_CLASSIFY: begin
            id_in    = files + 1'b1;
            scan_in  = '0;
            found_in = '0;
            pend_in  = 1'b0;
            state_in = iba_pkg::F_SEND;
            if ((iba_pkg::CFG_W'(idx_ff) >= limit_ff) || map_rd_data) begin
               status_in = iba_pkg::ST_INDEX;
            end else if (files >= MAXF) begin
               status_in = iba_pkg::ST_FULL;
            end else if (len_ff > MAX_LEN) begin
               status_in = iba_pkg::ST_SHORT;
            end else if (len_ff == '0) begin
               status_in = iba_pkg::ST_OK;
            end else begin
               status_in = iba_pkg::ST_OK;
               state_in  = iba_pkg::F_SCAN;
            end
         end
         iba_pkg::F_SCAN: begin
            scan_in      = issue ? (scan_ff + 1'b1) : scan_ff;
            pend_in      = issue;
            pend_addr_in = scan_ff[iba_pkg::BLK_W-1:0];
            found_in     = found_ff + CNT_W'(hit);
            if (found_ext == len_ff) begin
               status_in = iba_pkg::ST_OK;
               state_in  = iba_pkg::F_SEND;
            end else if (!issue && !pend_ff) begin
               status_in = iba_pkg::ST_SHORT;
               state_in  = iba_pkg::F_SEND;
            end
         end
         iba_pkg::F_SEND: begin
            state_in = iba_pkg::F_IDLE;
         end
         default: begin
            state_in = iba_pkg::F_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      case (state_ff)
         iba_pkg::F_IDLE: map_rd_addr = req.index_block;
         iba_pkg::F_SCAN: map_rd_addr = scan_ff[iba_pkg::BLK_W-1:0];
         default:         map_rd_addr = idx_ff;
      endcase
      q_wr_en         = hit;
      q_wr_addr       = found_ff[QA_W-1:0];
      q_wr_data       = pend_addr_ff;
      job.valid       = (state_ff == iba_pkg::F_SEND);
      job.status      = status_ff;
      job.file_id     = id_ff;
      job.index_block = idx_ff;
      job.length      = len_ff;
      busy            = (state_ff != iba_pkg::F_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= iba_pkg::F_IDLE;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      len_ff       <= len_in;
      limit_ff     <= limit_in;
      scan_ff      <= scan_in;
      pend_addr_ff <= pend_addr_in;
      found_ff     <= found_in;
      status_ff    <= status_in;
      id_ff        <= id_in;
   end

endmodule

`default_nettype wire

>>> sv/iba_back.sv
// back end: owner map clearing, block marking and result transfers
`default_nettype none

module iba_back #(
   parameter int MAX_FILE_BLOCKS = iba_pkg::MAX_FILE_BLOCKS
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire iba_pkg::job_type                       job,
   output      logic [((MAX_FILE_BLOCKS > 1) ? $clog2(MAX_FILE_BLOCKS) : 1)-1:0] q_rd_addr,
   input  wire logic [iba_pkg::BLK_W-1:0]              q_rd_data,
   output      logic                                   map_wr_en,
   output      logic [iba_pkg::BLK_W-1:0]              map_wr_addr,
   output      logic                                   map_wr_data,
   output      logic [iba_pkg::ID_W-1:0]               files,
   output      logic                                   rsp_valid,
   output      iba_pkg::rsp_type                       rsp,
   output      logic                                   busy
);

   localparam int CNT_W = $clog2(MAX_FILE_BLOCKS + 1);
   localparam int QA_W  = (MAX_FILE_BLOCKS > 1) ? $clog2(MAX_FILE_BLOCKS) : 1;
   localparam logic [iba_pkg::BLK_W-1:0] CLR_END = iba_pkg::BLK_W'(iba_pkg::DISK_BLOCKS - 1);

   iba_pkg::back_state_type state_ff, state_in;

   logic [iba_pkg::BLK_W-1:0] clr_ff, clr_in;
   iba_pkg::job_type          job_ff, job_in;
   logic [iba_pkg::ID_W-1:0]  files_ff, files_in;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;

   logic [CNT_W-1:0]          next_cnt;
   logic                      last_emit;

   assign next_cnt  = cnt_ff + 1'b1;
   assign last_emit = (iba_pkg::LEN_W'(next_cnt) == job_ff.length);

   // next state
   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      job_in   = job_ff;
      files_in = files_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         iba_pkg::B_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == CLR_END) begin
               state_in = iba_pkg::B_IDLE;
            end
         end
         iba_pkg::B_IDLE: begin
            if (job.valid) begin
               job_in   = job;
               cnt_in   = '0;
               state_in = (job.status == iba_pkg::ST_OK) ? iba_pkg::B_MARK
                                                         : iba_pkg::B_REPORT;
            end
         end
         iba_pkg::B_MARK: begin
            files_in = job_ff.file_id;
            state_in = (job_ff.length == '0) ? iba_pkg::B_REPORT : iba_pkg::B_EMIT;
         end
         iba_pkg::B_EMIT: begin
            cnt_in = next_cnt;
            if (last_emit) begin
               state_in = iba_pkg::B_IDLE;
            end
         end
         iba_pkg::B_REPORT: begin
            state_in = iba_pkg::B_IDLE;
         end
         default: begin
            state_in = iba_pkg::B_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      q_rd_addr        = (state_ff == iba_pkg::B_EMIT) ? next_cnt[QA_W-1:0]
                                                       : cnt_ff[QA_W-1:0];
      map_wr_en        = 1'b0;
      map_wr_addr      = clr_ff;
      map_wr_data      = 1'b0;
      rsp_valid        = 1'b0;
      rsp.status       = iba_pkg::ST_OK;
      rsp.file_id      = '0;
      rsp.block_number = '0;
      rsp.last         = 1'b1;
      case (state_ff)
         iba_pkg::B_CLEAR: begin
            map_wr_en = 1'b1;
         end
         iba_pkg::B_MARK: begin
            map_wr_en   = 1'b1;
            map_wr_addr = job_ff.index_block;
            map_wr_data = 1'b1;
         end
         iba_pkg::B_EMIT: begin
            map_wr_en        = 1'b1;
            map_wr_addr      = q_rd_data;
            map_wr_data      = 1'b1;
            rsp_valid        = 1'b1;
            rsp.file_id      = job_ff.file_id;
            rsp.block_number = q_rd_data;
            rsp.last         = last_emit;
         end
         iba_pkg::B_REPORT: begin
            rsp_valid   = 1'b1;
            rsp.status  = job_ff.status;
            rsp.file_id = (job_ff.status == iba_pkg::ST_OK) ? job_ff.file_id : '0;
         end
         default: begin
            map_wr_en = 1'b0;
         end
      endcase
      files = files_ff;
      busy  = (state_ff != iba_pkg::B_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= iba_pkg::B_CLEAR;
         clr_ff   <= '0;
         files_ff <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         files_ff <= files_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
      cnt_ff <= cnt_in;
   end

endmodule

`default_nettype wire

>>> sv/indexed_block_allocator.sv
// top level of the indexed block allocator
`default_nettype none

// After reset the block clears its owner map, one entry per cycle, and stays busy until
// all DISK_BLOCKS entries (1024 by default) are cleared before it takes its first request.
// A request is checked in the CLASSIFY state after it is accepted; a request that gets past
// the checks and asks for blocks scans the owner map from block 0, one block per cycle
// through the map's read port, until enough free blocks are found or the scan reaches the
// managed block count. The SEND state hands the request to the back end, the MARK state
// marks the index block, and the data blocks then come out one per cycle in ascending order,
// the last one flagged. A rejected request or a zero-length file gives a single result.
// Results cannot be held off: each is shown for one cycle with rsp_valid high. busy stays
// high from the accepted request until its last result has gone. csr_data may be written
// whenever busy is low and no request is being started.

module indexed_block_allocator #(
   parameter int MAX_FILE_BLOCKS = iba_pkg::MAX_FILE_BLOCKS
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   output      logic                        busy,
   input  wire iba_pkg::req_type            req,
   output      logic                        rsp_valid,
   output      iba_pkg::rsp_type            rsp,
   input  wire logic                        csr_valid,
   output      logic                        csr_ready,
   input  wire logic [iba_pkg::CFG_W-1:0]   csr_data
);

   localparam int QA_W = (MAX_FILE_BLOCKS > 1) ? $clog2(MAX_FILE_BLOCKS) : 1;

   logic [iba_pkg::CFG_W-1:0] blocks_in_use_ff, blocks_in_use_in;

   logic                      accept;
   logic                      front_busy;
   logic                      back_busy;
   iba_pkg::job_type          job;
   logic [iba_pkg::ID_W-1:0]  files;

   logic [iba_pkg::BLK_W-1:0] map_rd_addr;
   logic                      map_rd_data;
   logic                      map_wr_en;
   logic [iba_pkg::BLK_W-1:0] map_wr_addr;
   logic                      map_wr_data;

   logic                      q_wr_en;
   logic [QA_W-1:0]           q_wr_addr;
   logic [iba_pkg::BLK_W-1:0] q_wr_data;
   logic [QA_W-1:0]           q_rd_addr;
   logic [iba_pkg::BLK_W-1:0] q_rd_data;

   assign csr_ready        = 1'b1;
   assign blocks_in_use_in = (csr_valid && csr_ready) ? csr_data : blocks_in_use_ff;
   assign busy             = front_busy | back_busy;
   assign accept           = start & ~busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         blocks_in_use_ff <= iba_pkg::CFG_RESET;
      end else begin
         blocks_in_use_ff <= blocks_in_use_in;
      end
   end

   iba_front #(
      .MAX_FILE_BLOCKS(MAX_FILE_BLOCKS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .req          (req),
      .blocks_in_use(blocks_in_use_ff),
      .files        (files),
      .map_rd_addr  (map_rd_addr),
      .map_rd_data  (map_rd_data),
      .q_wr_en      (q_wr_en),
      .q_wr_addr    (q_wr_addr),
      .q_wr_data    (q_wr_data),
      .job          (job),
      .busy         (front_busy)
   );

   iba_ram #(
      .WIDTH(iba_pkg::BLK_W),
      .DEPTH(MAX_FILE_BLOCKS)
   ) u_cand_ram (
      .clock  (clock),
      .wr_en  (q_wr_en),
      .wr_addr(q_wr_addr),
      .wr_data(q_wr_data),
      .rd_addr(q_rd_addr),
      .rd_data(q_rd_data)
   );

   iba_back #(
      .MAX_FILE_BLOCKS(MAX_FILE_BLOCKS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .job        (job),
      .q_rd_addr  (q_rd_addr),
      .q_rd_data  (q_rd_data),
      .map_wr_en  (map_wr_en),
      .map_wr_addr(map_wr_addr),
      .map_wr_data(map_wr_data),
      .files      (files),
      .rsp_valid  (rsp_valid),
      .rsp        (rsp),
      .busy       (back_busy)
   );

   iba_ram #(
      .WIDTH(1),
      .DEPTH(iba_pkg::DISK_BLOCKS)
   ) u_owner_ram (
      .clock  (clock),
      .wr_en  (map_wr_en),
      .wr_addr(map_wr_addr),
      .wr_data(map_wr_data),
      .rd_addr(map_rd_addr),
      .rd_data(map_rd_data)
   );

endmodule

`default_nettype wire

>>> sv/iba_checker.sv
// port-level checks for the indexed block allocator
`default_nettype none

module iba_checker (
   input wire logic                      clock,
   input wire logic                      reset,
   input wire logic                      start,
   input wire logic                      busy,
   input wire logic                      rsp_valid,
   input wire iba_pkg::rsp_type          rsp
);

   // results only come while a request is in flight
   a_rsp_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result transfer while idle");

   // an accepted request keeps the block busy
   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("not busy after accepted request");

   // results of one request come back to back
   a_burst_contiguous: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp.last) |=> rsp_valid)
      else $error("gap inside a result burst");

   // a rejected request gives one clean result
   a_error_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp.status != iba_pkg::ST_OK)) |->
         (rsp.last && (rsp.file_id == '0) && (rsp.block_number == '0)))
      else $error("malformed error result");

   // the same file id runs through a whole burst
   a_burst_same_id: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp.last) |=> (rsp.file_id == $past(rsp.file_id)))
      else $error("file id changed inside a burst");

endmodule

bind indexed_block_allocator iba_checker u_iba_checker (
   .clock    (clock),
   .reset    (reset),
   .start    (start),
   .busy     (busy),
   .rsp_valid(rsp_valid),
   .rsp      (rsp)
);

`default_nettype wire

>>> test/indexed_block_allocator_test.sv
// self-checking testbench for the indexed block allocator: directed table, then random phases
`timescale 1ns / 100ps

module indexed_block_allocator_test;

   localparam int NUM_STEPS  = 23;
   localparam int NUM_PHASES = 8;

   localparam iba_pkg::rsp_type INDEX_ERR = '{iba_pkg::ST_INDEX, 10'd0, 10'd0, 1'b1};
   localparam iba_pkg::rsp_type SHORT_ERR = '{iba_pkg::ST_SHORT, 10'd0, 10'd0, 1'b1};
   localparam iba_pkg::rsp_type NO_RSP    = '{iba_pkg::ST_OK, 10'd0, 10'd0, 1'b0};

   typedef struct {
      bit                        csr_write;
      logic [iba_pkg::CFG_W-1:0] csr_value;
      iba_pkg::req_type          item;
      bit                        typed;
      iba_pkg::rsp_type          want;
   } step_row_type;

   logic                      clock     = 1'b0;
   logic                      reset     = 1'b1;
   logic                      start     = 1'b0;
   iba_pkg::req_type          req       = '0;
   logic                      csr_valid = 1'b0;
   logic [iba_pkg::CFG_W-1:0] csr_data  = '0;
   logic                      busy;
   logic                      rsp_valid;
   logic                      csr_ready;
   iba_pkg::rsp_type          rsp;

   logic [iba_pkg::ID_W-1:0]  owner_map [iba_pkg::DISK_BLOCKS];
   logic [iba_pkg::CFG_W-1:0] scan_limit;
   int                        files_made;
   int                        mismatch_count;
   int                        requests_sent;
   int                        limit_writes;
   int                        status_count [4];
   bit                        quiet;
   iba_pkg::rsp_type          pending_responses [$];
   iba_pkg::rsp_type          grant_list [$];
   iba_pkg::rsp_type          oldest;

   step_row_type directed_steps [NUM_STEPS] = '{
      '{1'b0, 11'd0,    '{10'd0,    7'd0},   1'b1, '{iba_pkg::ST_OK, 10'd1, 10'd0, 1'b1}},
      '{1'b0, 11'd0,    '{10'd0,    7'd1},   1'b1, INDEX_ERR},
      '{1'b0, 11'd0,    '{10'd1023, 7'd64},  1'b0, NO_RSP},
      '{1'b0, 11'd0,    '{10'd1023, 7'd0},   1'b1, INDEX_ERR},
      '{1'b0, 11'd0,    '{10'd100,  7'd65},  1'b1, SHORT_ERR},
      '{1'b0, 11'd0,    '{10'd100,  7'd127}, 1'b1, SHORT_ERR},
      '{1'b0, 11'd0,    '{10'd200,  7'd1},   1'b0, NO_RSP},
      '{1'b0, 11'd0,    '{10'd66,   7'd3},   1'b0, NO_RSP},
      '{1'b0, 11'd0,    '{10'd512,  7'd7},   1'b0, NO_RSP},
      '{1'b0, 11'd0,    '{10'd682,  7'd85},  1'b1, SHORT_ERR},
      '{1'b0, 11'd0,    '{10'd341,  7'd42},  1'b0, NO_RSP},
      '{1'b1, 11'd0,    '{10'd0,    7'd0},   1'b0, NO_RSP},
      '{1'b0, 11'd0,    '{10'd0,    7'd0},   1'b1, INDEX_ERR},
      '{1'b0, 11'd0,    '{10'd300,  7'd0},   1'b1, INDEX_ERR},
      '{1'b1, 11'd2047, '{10'd0,    7'd0},   1'b0, NO_RSP},
      '{1'b0, 11'd0,    '{10'd1022, 7'd2},   1'b0, NO_RSP},
      '{1'b1, 11'd130,  '{10'd0,    7'd0},   1'b0, NO_RSP},
      '{1'b0, 11'd0,    '{10'd130,  7'd0},   1'b1, INDEX_ERR},
      '{1'b0, 11'd0,    '{10'd129,  7'd9},   1'b0, NO_RSP},
      '{1'b0, 11'd0,    '{10'd129,  7'd8},   1'b0, NO_RSP},
      '{1'b1, 11'd1,    '{10'd0,    7'd0},   1'b0, NO_RSP},
      '{1'b0, 11'd0,    '{10'd0,    7'd0},   1'b1, INDEX_ERR},
      '{1'b1, 11'd1024, '{10'd0,    7'd0},   1'b0, NO_RSP}
   };

   int phase_limit [NUM_PHASES] = '{260, 0, 520, 1, 2047, 1025, 800, 1024};
   int phase_items [NUM_PHASES] = '{45, 6, 60, 6, 55, 45, 40, 35};

   indexed_block_allocator i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req       (req),
      .rsp_valid (rsp_valid),
      .rsp       (rsp),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   task automatic report_mismatch(input string what);
      if (mismatch_count < 100) begin
         $display("ERROR at %0t ns: %s", $time, what);
      end
      mismatch_count++;
   endtask

   function automatic void predict_allocation(input iba_pkg::req_type item);
      int                       lim;
      logic [iba_pkg::ID_W-1:0] id;
      int                       picks [$];
      iba_pkg::rsp_type         res;
      grant_list.delete();
      lim = (scan_limit > iba_pkg::DISK_BLOCKS) ? iba_pkg::DISK_BLOCKS : int'(scan_limit);
      res = INDEX_ERR;
      if (int'(item.index_block) >= lim || owner_map[item.index_block] != '0) begin
         grant_list.push_back(res);
         return;
      end
      if (files_made >= iba_pkg::MAX_FILES) begin
         res.status = iba_pkg::ST_FULL;
         grant_list.push_back(res);
         return;
      end
      if (item.length > iba_pkg::MAX_FILE_BLOCKS) begin
         res.status = iba_pkg::ST_SHORT;
         grant_list.push_back(res);
         return;
      end
      id = iba_pkg::ID_W'(files_made + 1);
      owner_map[item.index_block] = id;
      for (int j = 0; j < lim && picks.size() < int'(item.length); j++) begin
         if (owner_map[j] == '0) picks.push_back(j);
      end
      if (picks.size() < int'(item.length)) begin
         owner_map[item.index_block] = '0;
         res.status = iba_pkg::ST_SHORT;
         grant_list.push_back(res);
         return;
      end
      files_made++;
      res = '{iba_pkg::ST_OK, id, iba_pkg::BLK_W'(0), 1'b1};
      if (item.length == 0) begin
         grant_list.push_back(res);
         return;
      end
      foreach (picks[i]) begin
         owner_map[picks[i]] = id;
         res.block_number = iba_pkg::BLK_W'(picks[i]);
         res.last = (i == picks.size() - 1);
         grant_list.push_back(res);
      end
   endfunction

   task automatic issue_request(input iba_pkg::req_type item, input bit typed,
                                input iba_pkg::rsp_type want);
      start <= 1'b1;
      req   <= item;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      predict_allocation(item);
      if (typed) begin
         pending_responses.push_back(want);
      end else begin
         foreach (grant_list[g]) pending_responses.push_back(grant_list[g]);
      end
      requests_sent++;
   endtask

   task automatic idle_gap();
      if (!quiet && $urandom_range(99) < 13) begin
         start <= 1'b0;
         if ($urandom_range(3) == 0) begin
            repeat ($urandom_range(1500, 1)) @(posedge clock);
         end else begin
            repeat ($urandom_range(8, 1)) @(posedge clock);
         end
      end
   endtask

   task automatic set_scan_limit(input logic [iba_pkg::CFG_W-1:0] value);
      do @(negedge clock); while (pending_responses.size() != 0);
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      repeat ($urandom_range(3)) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
      scan_limit = value;
      limit_writes++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1) begin
         status_count[rsp.status]++;
         if (pending_responses.size() == 0) begin
            report_mismatch($sformatf("unexpected result status %0d id %0d block %0d",
                                      rsp.status, rsp.file_id, rsp.block_number));
         end else begin
            oldest = pending_responses.pop_front();
            if (rsp.status !== oldest.status)
               report_mismatch($sformatf("status %0d, expected %0d (file %0d)",
                                         rsp.status, oldest.status, oldest.file_id));
            if (rsp.file_id !== oldest.file_id)
               report_mismatch($sformatf("file_id %0d, expected %0d",
                                         rsp.file_id, oldest.file_id));
            if (rsp.block_number !== oldest.block_number)
               report_mismatch($sformatf("block_number %0d, expected %0d (file %0d)",
                                         rsp.block_number, oldest.block_number, oldest.file_id));
            if (rsp.last !== oldest.last)
               report_mismatch($sformatf("last %0b, expected %0b (file %0d block %0d)",
                                         rsp.last, oldest.last, oldest.file_id,
                                         oldest.block_number));
         end
      end
   end

   initial begin
      int                        lim;
      int                        tries;
      int                        pick;
      logic [iba_pkg::BLK_W-1:0] idx;
      logic [iba_pkg::LEN_W-1:0] len;
      foreach (owner_map[k]) owner_map[k] = '0;
      scan_limit = iba_pkg::CFG_RESET;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_steps[s]) begin
         if (directed_steps[s].csr_write) begin
            start <= 1'b0;
            set_scan_limit(directed_steps[s].csr_value);
         end else begin
            issue_request(directed_steps[s].item, directed_steps[s].typed,
                          directed_steps[s].want);
            idle_gap();
         end
      end

      for (int p = 0; p < NUM_PHASES; p++) begin
         start <= 1'b0;
         set_scan_limit(iba_pkg::CFG_W'(phase_limit[p]));
         quiet = (p == 4);
         lim = (scan_limit > iba_pkg::DISK_BLOCKS) ? iba_pkg::DISK_BLOCKS : int'(scan_limit);
         for (int n = 0; n < phase_items[p]; n++) begin
            idx = iba_pkg::BLK_W'($urandom);
            if (lim > 0 && $urandom_range(99) < 75) begin
               for (tries = 0; tries < 40; tries++) begin
                  idx = iba_pkg::BLK_W'($urandom_range(lim - 1));
                  if (owner_map[idx] == '0) break;
               end
            end
            pick = $urandom_range(99);
            if (pick < 55)      len = iba_pkg::LEN_W'($urandom_range(3));
            else if (pick < 85) len = iba_pkg::LEN_W'($urandom_range(12, 4));
            else if (pick < 94) len = iba_pkg::LEN_W'($urandom_range(64, 13));
            else                len = iba_pkg::LEN_W'($urandom_range(127, 65));
            issue_request('{idx, len}, 1'b0, NO_RSP);
            idle_gap();
         end
      end

      start <= 1'b0;
      tries = 0;
      while (pending_responses.size() != 0 && tries < 5000) begin
         @(posedge clock);
         tries++;
      end
      repeat (100) @(posedge clock);
      if (pending_responses.size() != 0)
         report_mismatch($sformatf("%0d expected results never arrived",
                                   pending_responses.size()));

      $display("covered %0d requests across %0d scan limit settings, %0d files created",
               requests_sent, limit_writes, files_made);
      $display("results seen by status: ok %0d, index %0d, short %0d, full %0d",
               status_count[iba_pkg::ST_OK], status_count[iba_pkg::ST_INDEX],
               status_count[iba_pkg::ST_SHORT], status_count[iba_pkg::ST_FULL]);
      if (mismatch_count == 0) begin
         $display("PASS indexed_block_allocator");
      end else begin
         $display("FAIL indexed_block_allocator");
      end
      $finish;
   end

   initial begin
      #8_000_000;
      $display("FAIL indexed_block_allocator");
      $finish;
   end

endmodule

>>> files.f
sv/iba_pkg.sv
sv/iba_ram.sv
sv/iba_front.sv
sv/iba_back.sv
sv/indexed_block_allocator.sv
sv/iba_checker.sv
test/indexed_block_allocator_test.sv
